// File: rtl/mts_pkg.sv
package mts_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  localparam logic signed [DataW-1:0] EMPTY_READ = '1;

  typedef struct packed {
    logic       push_en;
    logic       pop_en;
    logic       fetch_en;
    logic       top_load;
    logic       out_load;
    logic [1:0] status;
  } mts_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic one_left;
  } mts_stat_t;

endpackage

// File: rtl/mts_ram.sv
module mts_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mts_ctrl.sv
module mts_ctrl
  import mts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  logic [1:0] opcode_i,
  output logic      m_tvalid_o,
  input  logic      m_tready_i,
  input  mts_stat_t stat_i,
  output mts_cmd_t  cmd_o
);

  localparam logic S_ACCEPT = 1'b0;
  localparam logic S_FETCH  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic acc, is_push, is_pop;

  assign s_tready_o = (state_q == S_ACCEPT) && (!out_valid_q || m_tready_i);
  assign acc        = s_tvalid_i && s_tready_o;
  assign is_push    = (opcode_i == OP_PUSH);
  assign is_pop     = (opcode_i == OP_POP);

  always_comb begin
    cmd_o          = '0;
    cmd_o.push_en  = acc && is_push && !stat_i.full;
    cmd_o.pop_en   = acc && is_pop && !stat_i.empty;
    cmd_o.fetch_en = cmd_o.pop_en && !stat_i.one_left;
    cmd_o.top_load = (state_q == S_FETCH);
    cmd_o.out_load = (acc && !cmd_o.fetch_en) || cmd_o.top_load;
    if (acc && is_push && stat_i.full) begin
      cmd_o.status = ST_OVERFLOW;
    end else if (acc && is_pop && stat_i.empty) begin
      cmd_o.status = ST_UNDERFLOW;
    end else begin
      cmd_o.status = ST_OK;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_ACCEPT: begin
        if (cmd_o.fetch_en) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_ACCEPT;
      end
      default: begin
        state_d = S_ACCEPT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACCEPT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

  // a pending pop never finds the result register occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |-> !out_valid_q)
    else $error("result register busy during top fetch");

  // a pop that needs the next entry is followed by the fetch cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fetch_en |=> (state_q == S_FETCH) && cmd_o.out_load)
    else $error("top fetch not completed");

  // no transaction is overwritten before it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_tready_i))
    else $error("result overwritten");

  // the stack never pushes when full or pops when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.push_en && stat_i.full) && !(cmd_o.pop_en && stat_i.empty))
    else $error("stack bound violated");

endmodule

// File: rtl/mts_dp.sv
module mts_dp
  import mts_pkg::*;
#(
  parameter int unsigned Depth = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mts_cmd_t                cmd_i,
  output mts_stat_t               stat_o,
  input  logic signed [DataW-1:0] push_value_i,
  output logic signed [DataW-1:0] top_value_o,
  output logic signed [DataW-1:0] min_value_o,
  output logic                    is_empty_o,
  output logic [1:0]              status_o
);

  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned AddrW = $clog2(Depth);

  logic [CntW-1:0]          count_q, count_d;
  logic signed [DataW-1:0]  top_q, top_d;
  logic signed [DataW-1:0]  tmin_q, tmin_d;
  logic signed [DataW-1:0]  push_min;
  logic [2*DataW-1:0]       rdata;
  logic [CntW-1:0]          raddr_full;
  logic signed [DataW-1:0]  out_top_q, out_min_q;
  logic                     out_empty_q;
  logic [1:0]               out_status_q;

  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CntW'(Depth));
  assign stat_o.one_left = (count_q == CntW'(1));

  assign push_min   = (!stat_o.empty && (tmin_q < push_value_i)) ? tmin_q : push_value_i;
  assign raddr_full = count_q - CntW'(2);

  mts_ram #(
    .Width(2 * DataW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push_en),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i({push_min, push_value_i}),
    .re_i   (cmd_i.fetch_en),
    .raddr_i(raddr_full[AddrW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    count_d = count_q;
    top_d   = top_q;
    tmin_d  = tmin_q;
    if (cmd_i.push_en) begin
      count_d = count_q + CntW'(1);
      top_d   = push_value_i;
      tmin_d  = push_min;
    end else if (cmd_i.pop_en) begin
      count_d = count_q - CntW'(1);
    end else if (cmd_i.top_load) begin
      top_d  = rdata[DataW-1:0];
      tmin_d = rdata[2*DataW-1:DataW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    tmin_q <= tmin_d;
    if (cmd_i.out_load) begin
      out_empty_q  <= (count_d == '0);
      out_top_q    <= (count_d == '0) ? EMPTY_READ : top_d;
      out_min_q    <= (count_d == '0) ? EMPTY_READ : tmin_d;
      out_status_q <= cmd_i.status;
    end
  end

  assign top_value_o = out_top_q;
  assign min_value_o = out_min_q;
  assign is_empty_o  = out_empty_q;
  assign status_o    = out_status_q;

endmodule

// File: rtl/min_tracking_stack.sv
// Bounded LIFO stack of signed 32-bit values that also reports the minimum of
// everything it holds. Each input transaction carries an opcode in tuser (push,
// pop, or query for any other code) and the push value in tdata; each gives one
// result transaction with the top value and the minimum after the operation
// (both -1 when empty), an empty flag and a status (ok, pop on empty ignored,
// push on full dropped). A push, a query, a rejected operation or a pop that
// empties the stack loads its result directly; a pop that leaves entries passes
// through a fetch state, as the new top comes back from the entry RAM through
// its registered read port. A finished result sits in an output register; while
// it waits the input is held off, and the next transaction is taken in the
// cycle that the result is taken. The RAM needs no clearing after reset.
module min_tracking_stack
  import mts_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,   // push_value
  input  logic [1:0]  s_tuser_i,   // opcode
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [63:0] m_tdata_o,   // top_value, min_value
  output logic [2:0]  m_tuser_o    // is_empty, status
);

  mts_cmd_t                cmd;
  mts_stat_t               stat;
  logic signed [DataW-1:0] top_value, min_value;
  logic                    is_empty;
  logic [1:0]              status;

  mts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .opcode_i  (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  mts_dp #(
    .Depth(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .push_value_i(s_tdata_i),
    .top_value_o (top_value),
    .min_value_o (min_value),
    .is_empty_o  (is_empty),
    .status_o    (status)
  );

  assign m_tdata_o = {min_value, top_value};
  assign m_tuser_o = {status, is_empty};

endmodule

// File: tb/sv/testbench.sv
module testbench
  import mts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth     = 64;
  localparam int unsigned RandomOps = 1400;
  localparam int unsigned QuietFrom = 1500;
  localparam int unsigned QuietTo   = 2300;

  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
  } stack_op_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic signed [31:0] min_value;
    logic               is_empty;
    logic [1:0]         status;
  } stack_view_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;

  stack_op_t   pending_ops[$];
  stack_view_t expected_views[$];

  logic signed [31:0] held_value[Depth];
  logic signed [31:0] held_least[Depth];
  int unsigned        held_count = 0;
  int unsigned        plan_level = 0;

  int unsigned cyc       = 0;
  int unsigned errors    = 0;
  int unsigned n_push    = 0;
  int unsigned n_pop     = 0;
  int unsigned n_query   = 0;
  int unsigned n_over    = 0;
  int unsigned n_under   = 0;
  int unsigned n_results = 0;

  min_tracking_stack #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready),
    .s_tdata_i (s_tdata),
    .s_tuser_i (s_tuser),
    .m_tvalid_o(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata),
    .m_tuser_o (m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stack state after one operation, updates the shadow copy
  function automatic stack_view_t apply_op(stack_op_t item);
    stack_view_t        view;
    logic signed [31:0] least;
    view.status = ST_OK;
    if (item.op == OP_PUSH) begin
      if (held_count == Depth) begin
        view.status = ST_OVERFLOW;
      end else begin
        least = item.value;
        if (held_count > 0 && held_least[held_count-1] < least) begin
          least = held_least[held_count-1];
        end
        held_value[held_count] = item.value;
        held_least[held_count] = least;
        held_count++;
      end
    end else if (item.op == OP_POP) begin
      if (held_count == 0) begin
        view.status = ST_UNDERFLOW;
      end else begin
        held_count--;
      end
    end
    if (held_count == 0) begin
      view.top_value = EMPTY_READ;
      view.min_value = EMPTY_READ;
      view.is_empty  = 1'b1;
    end else begin
      view.top_value = held_value[held_count-1];
      view.min_value = held_least[held_count-1];
      view.is_empty  = 1'b0;
    end
    return view;
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] r;
    r = $urandom >> $urandom_range(31);
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return 32'(int'($urandom_range(16)) - 8);
      7: begin
        case ($urandom_range(3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default:    return ($urandom_range(1) != 0) ? -r : r;
    endcase
  endfunction

  function automatic logic [1:0] pick_op(int unsigned push_pct, int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_pct) return OP_PUSH;
    if (r < push_pct + pop_pct) return OP_POP;
    if (r < push_pct + pop_pct + (100 - push_pct - pop_pct) * 2 / 3) return OP_QUERY;
    return OP_SPARE;
  endfunction

  task automatic queue_op(logic [1:0] op, logic [31:0] value);
    stack_op_t item;
    item.op    = op;
    item.value = value;
    pending_ops.push_back(item);
    if (op == OP_PUSH && plan_level < Depth) plan_level++;
    if (op == OP_POP && plan_level > 0) plan_level--;
  endtask

  initial begin
    int unsigned directed_count;
    queue_op(OP_POP,   32'h0);
    queue_op(OP_QUERY, 32'h0);
    queue_op(OP_SPARE, 32'hFFFF_FFFF);
    queue_op(OP_PUSH,  32'd5);
    queue_op(OP_PUSH,  32'd7);
    queue_op(OP_PUSH,  32'd5);
    queue_op(OP_PUSH,  32'h7FFF_FFFF);
    queue_op(OP_PUSH,  32'h8000_0000);
    queue_op(OP_PUSH,  32'h0);
    queue_op(OP_PUSH,  32'hFFFF_FFFF);
    queue_op(OP_QUERY, 32'h1234_5678);
    queue_op(OP_SPARE, 32'h0);
    repeat (7) queue_op(OP_POP, 32'hFFFF_FFFF);
    queue_op(OP_POP,   32'h0);
    queue_op(OP_PUSH,  32'h8000_0000);
    queue_op(OP_POP,   32'h0);
    directed_count = pending_ops.size();

    // climbs to full, drains to empty, and mixed stretches in between
    while (pending_ops.size() < directed_count + RandomOps) begin
      case ($urandom_range(2))
        0: begin
          while (plan_level < Depth) queue_op(pick_op(85, 10), pick_value());
          repeat ($urandom_range(1, 3)) queue_op(OP_PUSH, pick_value());
        end
        1: begin
          while (plan_level > 0) queue_op(pick_op(10, 85), pick_value());
          repeat ($urandom_range(1, 3)) queue_op(OP_POP, pick_value());
        end
        default: begin
          repeat ($urandom_range(20, 60)) queue_op(pick_op(45, 40), pick_value());
        end
      endcase
    end

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || s_tvalid || expected_views.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    $display("covered %0d push, %0d pop and %0d query transactions, %0d results checked",
             n_push, n_pop, n_query, n_results);
    $display("results with push on full dropped: %0d, pop on empty ignored: %0d",
             n_over, n_under);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    stack_op_t item;
    logic      quiet;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
    end else begin
      cyc   <= cyc + 1;
      quiet  = cyc >= QuietFrom && cyc < QuietTo;
      if (s_tvalid && s_tready) begin
        item.op    = s_tuser;
        item.value = s_tdata;
        expected_views.push_back(apply_op(item));
        if (s_tuser == OP_PUSH) n_push++;
        else if (s_tuser == OP_POP) n_pop++;
        else n_query++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ops.size() != 0 && (quiet || $urandom_range(99) >= 20)) begin
          item      = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= item.op;
          s_tdata  <= item.value;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    stack_view_t got;
    stack_view_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.top_value = m_tdata[31:0];
        got.min_value = m_tdata[63:32];
        got.is_empty  = m_tuser[0];
        got.status    = m_tuser[2:1];
        n_results++;
        if (got.status == ST_OVERFLOW) n_over++;
        if (got.status == ST_UNDERFLOW) n_under++;
        if (expected_views.size() == 0) begin
          errors++;
          $display("%0t: unexpected result top %0d min %0d empty %0b status %0d",
                   $time, got.top_value, got.min_value, got.is_empty, got.status);
        end else begin
          want = expected_views.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: expected top %0d min %0d empty %0b status %0d", $time,
                     want.top_value, want.min_value, want.is_empty, want.status);
            $display("%0t:   actual top %0d min %0d empty %0b status %0d", $time,
                     got.top_value, got.min_value, got.is_empty, got.status);
          end
        end
      end
      m_tready <= (cyc >= QuietFrom && cyc < QuietTo) || $urandom_range(99) >= 20;
    end
  end

endmodule
